/* rtl/max_plus_iir2_four_lane_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef MAX_PLUS_IIR2_FOUR_LANE_MACROS_SVH
`define MAX_PLUS_IIR2_FOUR_LANE_MACROS_SVH

`ifndef ASSERT_OFF
`define MPI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MPI_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define MPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/mpiir_pkg.sv */
package mpiir_pkg;

  localparam int SAMPLE_W      = 32;
  localparam int TAP_W         = 16;
  localparam int DEFAULT_LANES = 4;
  localparam int DEFAULT_TAPS  = 3;
  localparam int CFG_INDEX_W   = 4;
  // Wide enough for any lookahead weight while the weight count NW is at most 32.
  localparam int WEIGHT_MAX_W  = 22;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TAP_ONE = 4'd0,
    REG_TAP_TWO = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic start;
  } stage_ctl_t;

  // The most negative sample means "no contribution" and absorbs any weight.
  function automatic sample_t sat_add(input sample_t v,
                                     input logic signed [WEIGHT_MAX_W-1:0] w);
    logic signed [SAMPLE_W:0] s;
    s = {v[SAMPLE_W-1], v} + {{(SAMPLE_W+1-WEIGHT_MAX_W){w[WEIGHT_MAX_W-1]}}, w};
    if (v == SAMPLE_MIN) return SAMPLE_MIN;
    if (s[SAMPLE_W] != s[SAMPLE_W-1]) return s[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
    return s[SAMPLE_W-1:0];
  endfunction

  function automatic sample_t smax(input sample_t a, input sample_t b);
    return (b > a) ? b : a;
  endfunction

endpackage

/* rtl/mpiir_weights.sv */
module mpiir_weights #(
  parameter int LANES = mpiir_pkg::DEFAULT_LANES,
  parameter int TAPS  = mpiir_pkg::DEFAULT_TAPS,
  parameter int NW    = LANES + TAPS - 1,
  parameter int WW    = mpiir_pkg::TAP_W + $clog2(NW) + 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mpiir_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic signed [mpiir_pkg::TAP_W-1:0]    cfg_data,
  output logic                                  busy,
  output logic [NW-1:0][WW-1:0]                 weights
);
  import mpiir_pkg::*;

  localparam int IDX_W = $clog2(NW);

  logic signed [TAP_W-1:0] tap_one;
  logic signed [TAP_W-1:0] tap_two;
  logic [NW-1:1][WW-1:0]   w;
  logic signed [WW-1:0]    prev1;
  logic signed [WW-1:0]    prev2;
  logic signed [WW-1:0]    cand1;
  logic signed [WW-1:0]    cand2;
  logic signed [WW-1:0]    step;
  logic [IDX_W-1:0]        idx;
  logic                    cfg_fire;
  logic                    known_reg;

  assign cfg_ready = !busy;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign known_reg = (cfg_index == REG_TAP_ONE) || (cfg_index == REG_TAP_TWO);
  assign weights   = {w, {WW{1'b0}}};

  // One lookahead weight per cycle: w[i] = max(w[i-1] + a, w[i-2] + b), the b term only when TAPS is 3.
  always_comb begin
    cand1 = prev1 + WW'(tap_one);
    cand2 = prev2 + WW'(tap_two);
    step  = cand1;
    if (TAPS == 3 && idx >= IDX_W'(2) && cand2 > cand1) step = cand2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_one <= '0;
      tap_two <= '0;
      busy    <= 1'b0;
      idx     <= IDX_W'(1);
      prev1   <= '0;
      prev2   <= '0;
      w       <= '0;
    end else if (cfg_fire) begin
      if (cfg_index == REG_TAP_ONE) tap_one <= cfg_data;
      if (cfg_index == REG_TAP_TWO) tap_two <= cfg_data;
      if (known_reg) begin
        busy  <= 1'b1;
        idx   <= IDX_W'(1);
        prev1 <= '0;
        prev2 <= '0;
      end
    end else if (busy) begin
      w[idx] <= step;
      prev2  <= prev1;
      prev1  <= step;
      idx    <= idx + IDX_W'(1);
      if (idx == IDX_W'(NW - 1)) busy <= 1'b0;
    end
  end

endmodule

/* rtl/mpiir_lane.sv */
module mpiir_lane #(
  parameter int LANES = mpiir_pkg::DEFAULT_LANES,
  parameter int WW    = mpiir_pkg::TAP_W + $clog2(LANES + 2) + 1
) (
  input  logic                                   clk,
  input  logic                                   load,
  // window[k] is the input sample k positions back from this lane's sample.
  input  logic [LANES-1:0][mpiir_pkg::SAMPLE_W-1:0] window,
  input  logic [LANES-1:0][WW-1:0]               weights,
  output logic [mpiir_pkg::SAMPLE_W-1:0]         partial
);
  import mpiir_pkg::*;

  sample_t t [LANES];

  // Weighted feed-forward terms, then a log-depth max tree.
  always_comb begin
    t[0] = window[0];
    for (int k = 1; k < LANES; k++) begin
      t[k] = sat_add(window[k], WEIGHT_MAX_W'($signed(weights[k])));
    end
    for (int s = 1; s < LANES; s = s * 2) begin
      for (int k = 0; k + s < LANES; k = k + 2 * s) begin
        t[k] = smax(t[k], t[k+s]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) partial <= t[0];
  end

endmodule

/* rtl/mpiir_merge.sv */
module mpiir_merge #(
  parameter int LANES = mpiir_pkg::DEFAULT_LANES,
  parameter int TAPS  = mpiir_pkg::DEFAULT_TAPS,
  parameter int WW    = mpiir_pkg::TAP_W + $clog2(LANES + TAPS - 1) + 1
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  mpiir_pkg::stage_ctl_t                     ctl,
  input  logic [LANES-1:0][mpiir_pkg::SAMPLE_W-1:0] partial,
  input  logic [TAPS-2:0][WW-1:0]                   wtail,
  output logic [LANES-1:0][mpiir_pkg::SAMPLE_W-1:0] result
);
  import mpiir_pkg::*;

  localparam int YHIST = LANES + TAPS - 2;

  // hist[0] is the most recent output.
  logic [YHIST-1:0][SAMPLE_W-1:0] hist;
  logic [YHIST-1:0][SAMPLE_W-1:0] hist_eff;
  logic [YHIST-1:0][SAMPLE_W-1:0] hist_next;
  logic [LANES-1:0][SAMPLE_W-1:0] y;
  sample_t                        r;

  always_comb begin
    for (int m = 0; m < YHIST; m++) begin
      hist_eff[m] = ctl.start ? SAMPLE_MIN : hist[m];
    end
    for (int j = 0; j < LANES; j++) begin
      r = partial[j];
      for (int t = 0; t < TAPS - 1; t++) begin
        r = smax(r, sat_add(hist_eff[LANES + t - j - 1],
                            WEIGHT_MAX_W'($signed(wtail[t]))));
      end
      y[j] = r;
    end
    for (int m = 0; m < YHIST; m++) begin
      if (m < LANES) hist_next[m] = y[LANES-1-m];
      else hist_next[m] = hist_eff[m-LANES];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= {YHIST{SAMPLE_MIN}};
    end else if (ctl.load) begin
      hist <= hist_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) result <= y;
  end

endmodule

/* rtl/max_plus_iir2_four_lane.sv */
// Channel  | Handshake             | Payload
// input    | s_tvalid / s_tready   | s_tdata: LANES samples, s_tuser: stream start
// output   | m_tvalid / m_tready   | m_tdata: LANES results
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data (tap weight)
//
// One block of LANES samples enters per cycle while no tap write is in progress and the output
// is not stalled; results pass through the lane partial registers, then the merge result register.
// The rate is set by the output history loop: each block's results feed the next block's merge.
// Reset clears both tap weights and fills the input and output history with minus infinity.
// A tap write re-derives the lookahead weights one per cycle, holding s_tready and cfg_ready
// low until the last weight is written.
`include "max_plus_iir2_four_lane_macros.svh"

module max_plus_iir2_four_lane #(
  parameter int LANES = mpiir_pkg::DEFAULT_LANES,
  parameter int TAPS  = mpiir_pkg::DEFAULT_TAPS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // sample_lane0 .. sample_lane(LANES-1), lowest bits first
  input  logic [LANES*mpiir_pkg::SAMPLE_W-1:0]   s_tdata,
  // stream_start
  input  logic                                   s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // result_lane0 .. result_lane(LANES-1), lowest bits first
  output logic [LANES*mpiir_pkg::SAMPLE_W-1:0]   m_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mpiir_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic signed [mpiir_pkg::TAP_W-1:0]     cfg_data
);
  import mpiir_pkg::*;

  localparam int NW    = LANES + TAPS - 1;
  localparam int WW    = TAP_W + $clog2(NW) + 1;
  localparam int XHIST = LANES - 1;

  logic [NW-1:0][WW-1:0]                 weights;
  logic                                  busy;
  logic [LANES-1:0][SAMPLE_W-1:0]        xin;
  logic [XHIST-1:0][SAMPLE_W-1:0]        px;
  logic [LANES-1:0][LANES-1:0][SAMPLE_W-1:0] win;
  logic [LANES-1:0][SAMPLE_W-1:0]        partial;
  logic [LANES-1:0][SAMPLE_W-1:0]        result;
  logic                                  s1_valid;
  logic                                  s1_start;
  logic                                  s1_move;
  logic                                  s_fire;
  stage_ctl_t                            merge_ctl;

  assign xin      = s_tdata;
  assign m_tdata  = result;
  assign s1_move  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !busy && (!s1_valid || s1_move);
  assign s_fire   = s_tvalid && s_tready;
  assign merge_ctl = '{load: s1_move, start: s1_start};

  mpiir_weights #(.LANES(LANES), .TAPS(TAPS), .NW(NW), .WW(WW)) u_weights (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .weights   (weights)
  );

  // Lane j sees x[n-k] from this block, or from the stored history once k reaches past lane 0.
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    for (genvar k = 0; k < LANES; k++) begin : g_win
      if (k <= j) begin : g_cur
        assign win[j][k] = xin[j-k];
      end else begin : g_hist
        assign win[j][k] = s_tuser ? SAMPLE_MIN : px[k-j-1];
      end
    end

    mpiir_lane #(.LANES(LANES), .WW(WW)) u_lane (
      .clk     (clk),
      .load    (s_fire),
      .window  (win[j]),
      .weights (weights[LANES-1:0]),
      .partial (partial[j])
    );
  end

  mpiir_merge #(.LANES(LANES), .TAPS(TAPS), .WW(WW)) u_merge (
    .clk     (clk),
    .rst     (rst),
    .ctl     (merge_ctl),
    .partial (partial),
    .wtail   (weights[NW-1:LANES]),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      px       <= {XHIST{SAMPLE_MIN}};
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_fire) begin
        for (int m = 0; m < XHIST; m++) begin
          px[m] <= xin[LANES-1-m];
        end
      end
      if (s_fire) s1_valid <= 1'b1;
      else if (s1_move) s1_valid <= 1'b0;
      if (s1_move) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) s1_start <= s_tuser;
  end

  `MPI_ASSERT_NEXT(a_tap_write_stalls_input, clk, rst, cfg_valid && cfg_ready && (cfg_index == REG_TAP_ONE || cfg_index == REG_TAP_TWO), !s_tready, "tap write did not stall the input")
  `MPI_ASSERT_NEXT(a_stage_holds_on_stall, clk, rst, s1_valid && m_tvalid && !m_tready, s1_valid, "stage item lost while output stalled")
  `MPI_ASSERT_IMPL(a_output_from_stage, clk, rst, $rose(m_tvalid), $past(s1_valid), "output became valid without a stage item")

endmodule
